### sv/clr_pkg.sv
// Shared types, codes and reset values for the comm-loss recovery block.
package clr_pkg;

    // Register indexes of the configuration port.
    localparam logic CFG_BLACKOUT_LIMIT  = 1'b0;
    localparam logic CFG_POWERCYCLE_WAIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [31:0] BLACKOUT_LIMIT_RST  = 32'd86400;
    localparam logic [31:0] POWERCYCLE_WAIT_RST = 32'd28800;

    // Requested mission modes.
    localparam logic [1:0] REQ_MANUAL   = 2'd0;
    localparam logic [1:0] REQ_STANDBY  = 2'd1;
    localparam logic [1:0] REQ_SAFEHOLD = 2'd2;

    // Stage numbers as reported on the result word.
    localparam logic [2:0] CODE_UNFAULTED = 3'd0;
    localparam logic [2:0] CODE_STANDBY   = 3'd1;
    localparam logic [2:0] CODE_PC1       = 3'd2;
    localparam logic [2:0] CODE_PC2       = 3'd3;
    localparam logic [2:0] CODE_PC3       = 3'd4;
    localparam logic [2:0] CODE_SAFEHOLD  = 3'd5;

    // Fault stage, one-hot.
    typedef enum logic [5:0] {
        ST_UNFAULTED = 6'b000001,
        ST_STANDBY   = 6'b000010,
        ST_PC1       = 6'b000100,
        ST_PC2       = 6'b001000,
        ST_PC3       = 6'b010000,
        ST_SAFEHOLD  = 6'b100000
    } t_stage;

    // Input word: one control-cycle tick.
    typedef struct packed {
        logic [31:0] now_cycle;
        logic [31:0] last_contact_cycle;
        logic        radio_off;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [1:0] mission_request;
        logic       power_cycle_pulse;
        logic [2:0] fault_stage;
    } t_out_word;

    // Fault state carried from tick to tick.
    typedef struct packed {
        t_stage      stage;
        logic [31:0] entry_cycle;
    } t_fsm_state;

endpackage

### sv/clr_step.sv
// Transition logic of the fault state machine for one tick.
module clr_step
    import clr_pkg::*;
(
    input  t_fsm_state  i_state,
    input  t_in_word    i_word,
    input  logic [31:0] i_blackout_limit,
    input  logic [31:0] i_powercycle_wait,
    output t_fsm_state  o_state,
    output t_out_word   o_word
);

    logic [31:0] since_contact;
    logic [31:0] in_stage;
    logic        blackout_hit;
    logic        hold_done;
    logic        wait_done;
    logic        contact_ok;

    // Wrapping elapsed times and the limit tests.
    assign since_contact = i_word.now_cycle - i_word.last_contact_cycle;
    assign in_stage      = i_word.now_cycle - i_state.entry_cycle;
    assign blackout_hit  = since_contact >= i_blackout_limit;
    assign contact_ok    = since_contact <= i_blackout_limit;
    assign hold_done     = in_stage >= i_blackout_limit;
    assign wait_done     = in_stage >= i_powercycle_wait;

    // Next stage, request and pulse.
    always_comb begin
        o_state                  = i_state;
        o_word.mission_request   = REQ_MANUAL;
        o_word.power_cycle_pulse = 1'b0;
        case (i_state.stage)
            ST_STANDBY: begin
                if (hold_done) begin
                    o_state.stage            = ST_PC1;
                    o_state.entry_cycle      = i_word.now_cycle;
                    o_word.mission_request   = REQ_STANDBY;
                    o_word.power_cycle_pulse = 1'b1;
                end
            end
            ST_PC1: begin
                if (wait_done) begin
                    o_state.stage            = ST_PC2;
                    o_state.entry_cycle      = i_word.now_cycle;
                    o_word.mission_request   = REQ_STANDBY;
                    o_word.power_cycle_pulse = 1'b1;
                end
            end
            ST_PC2: begin
                if (wait_done) begin
                    o_state.stage            = ST_PC3;
                    o_state.entry_cycle      = i_word.now_cycle;
                    o_word.mission_request   = REQ_STANDBY;
                    o_word.power_cycle_pulse = 1'b1;
                end
            end
            ST_PC3: begin
                if (wait_done) begin
                    o_state.stage          = ST_SAFEHOLD;
                    o_state.entry_cycle    = i_word.now_cycle;
                    o_word.mission_request = REQ_SAFEHOLD;
                end
            end
            ST_SAFEHOLD: begin
                if (contact_ok) begin
                    o_state.stage          = ST_UNFAULTED;
                    o_state.entry_cycle    = i_word.now_cycle;
                    o_word.mission_request = REQ_STANDBY;
                end else begin
                    o_word.mission_request = REQ_SAFEHOLD;
                end
            end
            default: begin
                o_state.stage = ST_UNFAULTED;
                if (!i_word.radio_off && blackout_hit) begin
                    o_state.stage          = ST_STANDBY;
                    o_state.entry_cycle    = i_word.now_cycle;
                    o_word.mission_request = REQ_STANDBY;
                end
            end
        endcase

        // Stage number of the stage after the step.
        case (o_state.stage)
            ST_STANDBY:  o_word.fault_stage = CODE_STANDBY;
            ST_PC1:      o_word.fault_stage = CODE_PC1;
            ST_PC2:      o_word.fault_stage = CODE_PC2;
            ST_PC3:      o_word.fault_stage = CODE_PC3;
            ST_SAFEHOLD: o_word.fault_stage = CODE_SAFEHOLD;
            default:     o_word.fault_stage = CODE_UNFAULTED;
        endcase
    end

endmodule

### sv/comm_loss_recovery_fsm.sv
// Top level of the comm-loss recovery block: word registers, state and configuration.
// Each input word is one control-cycle tick and yields exactly one result word. A word
// is taken into an input register, passes the stage-transition compare logic and lands
// in the output register; a new word is accepted on every clock while the output side
// keeps up, and a stall on the output holds both registers. The fault state is updated
// as each word moves to the output register, so words see the state left by the word
// before them. The user must have the blackout limit and the power-cycle wait written
// through the configuration port only while the block is idle; the block does not enforce
// this. Both return on reset to 86400 and 28800, in units of the now_cycle field.
module comm_loss_recovery_fsm
    import clr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    logic [31:0] r_blackout_limit;
    logic [31:0] r_powercycle_wait;
    t_fsm_state  r_state;
    t_fsm_state  n_state;
    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;
    logic        advance;

    // The input register moves on whenever the output register is free or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blackout_limit  <= BLACKOUT_LIMIT_RST;
            r_powercycle_wait <= POWERCYCLE_WAIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BLACKOUT_LIMIT) begin
                r_blackout_limit <= i_cfg_data;
            end else begin
                r_powercycle_wait <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Transition logic.
    clr_step u_step (
        .i_state           (r_state),
        .i_word            (r_in_word),
        .i_blackout_limit  (r_blackout_limit),
        .i_powercycle_wait (r_powercycle_wait),
        .o_state           (n_state),
        .o_word            (n_out_word)
    );

    // Fault state, updated as a word moves into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.stage       <= ST_UNFAULTED;
            r_state.entry_cycle <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### sim/testbench.sv
// Self-checking testbench for the comm-loss recovery block: directed and random tick words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clr_pkg::*;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 500;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_BLACKOUT_LIMIT;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;

    // Predicted fault state and register copies.
    logic [2:0]  fault_code      = CODE_UNFAULTED;
    logic [31:0] entry_cycle     = '0;
    logic [31:0] blackout_limit  = BLACKOUT_LIMIT_RST;
    logic [31:0] powercycle_wait = POWERCYCLE_WAIT_RST;

    t_out_word   expected_words[$];
    int          error_count   = 0;
    int          idle_cycles   = 0;
    int          in_gap_pct    = 0;
    int          out_stall_pct = 0;
    logic [31:0] walk_now      = '0;
    logic [31:0] walk_last     = '0;

    comm_loss_recovery_fsm u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Steps the predicted fault state by one tick and returns the result word it causes.
    function automatic t_out_word advance_fault_state(input t_in_word w);
        t_out_word   r;
        logic [31:0] since_contact;
        logic [31:0] in_stage;
        since_contact       = w.now_cycle - w.last_contact_cycle;
        in_stage            = w.now_cycle - entry_cycle;
        r.mission_request   = REQ_MANUAL;
        r.power_cycle_pulse = 1'b0;
        case (fault_code)
            CODE_STANDBY: begin
                if (in_stage >= blackout_limit) begin
                    r.power_cycle_pulse = 1'b1;
                    r.mission_request   = REQ_STANDBY;
                    fault_code          = CODE_PC1;
                    entry_cycle         = w.now_cycle;
                end
            end
            CODE_PC1, CODE_PC2: begin
                if (in_stage >= powercycle_wait) begin
                    r.power_cycle_pulse = 1'b1;
                    r.mission_request   = REQ_STANDBY;
                    fault_code          = fault_code + 3'd1;
                    entry_cycle         = w.now_cycle;
                end
            end
            CODE_PC3: begin
                // The last stage goes to safehold without a pulse.
                if (in_stage >= powercycle_wait) begin
                    r.mission_request = REQ_SAFEHOLD;
                    fault_code        = CODE_SAFEHOLD;
                    entry_cycle       = w.now_cycle;
                end
            end
            CODE_SAFEHOLD: begin
                if (since_contact <= blackout_limit) begin
                    r.mission_request = REQ_STANDBY;
                    fault_code        = CODE_UNFAULTED;
                    entry_cycle       = w.now_cycle;
                end else begin
                    r.mission_request = REQ_SAFEHOLD;
                end
            end
            default: begin
                fault_code = CODE_UNFAULTED;
                if (!w.radio_off && since_contact >= blackout_limit) begin
                    r.mission_request = REQ_STANDBY;
                    fault_code        = CODE_STANDBY;
                    entry_cycle       = w.now_cycle;
                end
            end
        endcase
        r.fault_stage = fault_code;
        return r;
    endfunction

    // Result side: random stall bursts, changed on the falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %p",
                         $time, o_out_word);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_word !== want) begin
                    $display("%0t: result mismatch: expected %p, actual %p",
                             $time, want, o_out_word);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one tick word, holds it until accepted, then records its prediction.
    task automatic send_tick(input t_in_word w);
        int gap;
        @(negedge i_clk);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            gap        = $urandom_range(1, 13);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  = w;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_words.push_back(advance_fault_state(w));
    endtask

    task automatic tick(input logic [31:0] now, input logic [31:0] last, input logic off);
        t_in_word w;
        w.now_cycle          = now;
        w.last_contact_cycle = last;
        w.radio_off          = off;
        send_tick(w);
    endtask

    // Lowers valid and waits until every predicted word has come out.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_BLACKOUT_LIMIT) begin
            blackout_limit = data;
        end else begin
            powercycle_wait = data;
        end
    endtask

    task automatic set_limits(input logic [31:0] blackout, input logic [31:0] wait_cycles);
        write_reg(CFG_BLACKOUT_LIMIT, blackout);
        write_reg(CFG_POWERCYCLE_WAIT, wait_cycles);
    endtask

    // Picks a new idling mix for both sides; zero gives stretches with no idling.
    task automatic choose_idling();
        int pick[3];
        pick          = '{0, 6, 25};
        in_gap_pct    = pick[$urandom_range(0, 2)];
        out_stall_pct = pick[$urandom_range(0, 2)];
    endtask

    // Random walk of ticks: mostly advancing time with rare contacts, some pure noise.
    task automatic run_walk(input int count, input logic [31:0] blackout,
                            input logic [31:0] wait_cycles);
        t_in_word    w;
        logic [31:0] span;
        logic [31:0] step;
        set_limits(blackout, wait_cycles);
        span = ((blackout > wait_cycles) ? blackout : wait_cycles) / 2 + 1;
        repeat (count) begin
            if ($urandom_range(0, 99) < 12) begin
                w.now_cycle          = $urandom;
                w.last_contact_cycle = $urandom;
                w.radio_off          = 1'($urandom_range(0, 1));
                walk_now             = w.now_cycle;
                walk_last            = w.last_contact_cycle;
            end else begin
                case ($urandom_range(0, 9))
                    0:       step = '0;
                    7, 8:    step = ($urandom_range(0, 1) ? blackout : wait_cycles)
                                    + $urandom_range(0, 2) - 1;
                    9:       step = $urandom;
                    default: step = $urandom_range(1, span);
                endcase
                walk_now = walk_now + step;
                // Occasional check-in, sometimes right at the recovery boundary.
                if ($urandom_range(0, 99) < 8) begin
                    walk_last = walk_now - $urandom_range(0, blackout);
                end
                w.now_cycle          = walk_now;
                w.last_contact_cycle = walk_last;
                w.radio_off          = ($urandom_range(0, 9) == 0);
            end
            send_tick(w);
        end
    endtask

    // Full fault ladder at the reset limits, including the radio-off hold.
    task automatic test_default_walk();
        in_gap_pct    = 20;
        out_stall_pct = 20;
        tick(32'd0,      32'd0,      1'b0);
        tick(32'd86399,  32'd0,      1'b0);
        tick(32'd86400,  32'd0,      1'b1);
        tick(32'd86400,  32'd0,      1'b0);
        tick(32'd172800, 32'd0,      1'b0);
        tick(32'd201599, 32'd0,      1'b0);
        tick(32'd201600, 32'd0,      1'b0);
        tick(32'd230400, 32'd0,      1'b0);
        tick(32'd259200, 32'd0,      1'b0);
        tick(32'd300000, 32'd0,      1'b0);
        tick(32'd300000, 32'd213600, 1'b0);
    endtask

    // Field extremes and wrapping differences.
    task automatic test_field_extremes();
        tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        tick(32'd5,         32'hFFFF_FFF0, 1'b0);
        tick(32'd0,         32'hFFFF_FFFF, 1'b0);
        tick(32'hFFFF_FFFF, 32'd0,         1'b1);
        tick(32'hFFFF_FFFF, 32'd0,         1'b0);
        // Standby hold time measured across the counter wrap.
        tick(32'h0001_517F, 32'd0,         1'b0);
    endtask

    // Zero limits: every test of an elapsed time against a limit with >= passes at once.
    task automatic test_zero_registers();
        set_limits(32'd0, 32'd0);
        tick(32'd10, 32'd10, 1'b1);
        tick(32'd10, 32'd10, 1'b1);
        tick(32'd10, 32'd10, 1'b0);
        tick(32'd11, 32'd10, 1'b0);
        tick(32'd11, 32'd11, 1'b0);
        tick(32'd11, 32'd11, 1'b1);
        tick(32'd11, 32'd11, 1'b0);
    endtask

    // All-ones limits: thresholds met only one count short of a full wrap.
    task automatic test_full_registers();
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tick(32'd100, 32'd0, 1'b0);
        tick(32'd10,  32'd0, 1'b0);
        tick(32'd9,   32'd5, 1'b0);
    endtask

    task automatic test_random_small_limits();
        repeat (5) begin
            choose_idling();
            run_walk(70, $urandom_range(1, 12), $urandom_range(1, 8));
        end
    endtask

    task automatic test_random_wide_limits();
        choose_idling();
        run_walk(40, 32'd0, 32'd0);
        choose_idling();
        run_walk(40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        choose_idling();
        run_walk(40, $urandom, $urandom);
        choose_idling();
        run_walk(40, $urandom, $urandom_range(1, 50));
        choose_idling();
        run_walk(40, BLACKOUT_LIMIT_RST, POWERCYCLE_WAIT_RST);
        choose_idling();
        run_walk(40, 32'd1, 32'd1);
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_streaming();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        run_walk(90, $urandom_range(1, 10), $urandom_range(1, 6));
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_walk();
        test_field_extremes();
        test_zero_registers();
        test_full_registers();
        test_random_small_limits();
        test_random_wide_limits();
        test_streaming();
        drain_results();
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### filelist.f
sv/clr_pkg.sv
sv/clr_step.sv
sv/comm_loss_recovery_fsm.sv
sim/testbench.sv
